### sv/sactc_pkg.sv
// Package with the shared types, register indexes and constants of the cache tag controller.
`timescale 1ns / 1ps

package sactc_pkg;

    // Configuration port geometry.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_POLICY   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLACE_POLICY = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_LOG2      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RANDOM_SEED    = 3'd5;

    // Register values after reset.
    localparam logic        RST_WRITE_POLICY   = 1'b1;
    localparam logic        RST_REPLACE_POLICY = 1'b0;
    localparam logic [3:0]  RST_OFFSET_BITS    = 4'd4;
    localparam logic [3:0]  RST_INDEX_BITS     = 4'd6;
    localparam logic [1:0]  RST_WAYS_LOG2      = 2'd2;
    localparam logic [15:0] RST_RANDOM_SEED    = 16'd44257;

    // Policy codes.
    localparam logic WP_WRITE_THROUGH = 1'b0;
    localparam logic WP_WRITE_BACK    = 1'b1;
    localparam logic RP_LRU           = 1'b0;
    localparam logic RP_RANDOM        = 1'b1;

    // Access kinds.
    localparam logic MODE_READ  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    // Address and tag width.
    localparam int ADDR_W = 32;

    // Galois LFSR feedback taps.
    localparam logic [15:0] LFSR_TAPS = 16'hB400;

    // Input word of one access.
    typedef struct packed {
        logic              mode;
        logic [ADDR_W-1:0] address;
    } t_req;

    // Result word of one access.
    typedef struct packed {
        logic hit;
        logic memory_fill;
        logic memory_write;
    } t_resp;

    // Control flags that steer the per-way compare and update unit.
    typedef struct packed {
        logic lru;
        logic hit;
        logic alloc;
        logic is_write;
        logic wb_write;
    } t_upd_ctl;

    // One step of the random replacement LFSR.
    function automatic logic [15:0] lfsr_step(input logic [15:0] s);
        logic [15:0] r;
        r = s >> 1;
        if (s[0]) begin
            r = r ^ LFSR_TAPS;
        end
        return r;
    endfunction

endpackage

### sv/set_assoc_cache_tag_controller.sv
// Top level of the set-associative cache tag controller with its access sequencer.
`timescale 1ns / 1ps

// One access word is taken when start is high and busy is low. The sequencer
// reads the ways of the addressed set one a cycle from a single tag RAM
// through one shared compare unit, picks the hit or victim way, then reads
// and rewrites every way of the set, one a cycle, through the same unit. Busy
// stays high until the update pass is done, and the result appears with
// o_strobe for one cycle as busy falls. The result must be taken in that
// cycle; the receiver cannot hold it off. No new access word is taken while
// one is in flight. The first access to a set after reset rewrites all
// MAX_WAYS ways of that set in its update pass. Each set carries a valid
// flag in flip-flops that reset clears, so the store reads as empty at once
// after reset and needs no clearing pass.
module set_assoc_cache_tag_controller
    import sactc_pkg::*;
#(
    parameter int MAX_SETS = 256,
    parameter int MAX_WAYS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  t_req                  i_req,
    output logic                  o_strobe,
    output t_resp                 o_resp,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Geometry that follows from the parameters.
    localparam int SET_LOG   = $clog2(MAX_SETS + 1) - 1;
    localparam int WAY_LOG   = $clog2(MAX_WAYS + 1) - 1;
    localparam int NSETS     = 1 << SET_LOG;
    localparam int SET_W     = (SET_LOG > 0) ? SET_LOG : 1;
    localparam int AGE_W     = (WAY_LOG > 0) ? WAY_LOG : 1;
    localparam int CNT_W     = WAY_LOG + 1;
    localparam int ENT_W     = ADDR_W + 2 + AGE_W;
    localparam int RAM_DEPTH = NSETS << WAY_LOG;
    localparam int RAM_AW    = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;

    // Sequencer states.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEC  = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_VICT = 3'd3;
    localparam logic [2:0] S_UPD  = 3'd4;

    // Control registers.
    logic [2:0]       r_state, n_state;
    logic             r_wp, n_wp;
    logic             r_rp, n_rp;
    logic [3:0]       r_off, n_off;
    logic [3:0]       r_idx, n_idx;
    logic [1:0]       r_wl, n_wl;
    logic [15:0]      r_lfsr, n_lfsr;
    logic [NSETS-1:0] r_set_valid, n_set_valid;
    logic [CNT_W-1:0] r_rd_way, n_rd_way;
    logic             r_dv, n_dv;
    logic             r_hit, n_hit;
    logic             r_inv_found, n_inv_found;
    logic             r_vict_wb, n_vict_wb;
    logic             r_alloc, n_alloc;
    logic             r_strobe, n_strobe;

    // Payload registers.
    logic             r_mode, n_mode;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic [SET_W-1:0] r_set, n_set;
    logic [ADDR_W-1:0] r_tag, n_tag;
    logic [CNT_W-1:0] r_ways, n_ways;
    logic [AGE_W-1:0] r_top, n_top;
    logic [AGE_W-1:0] r_dway, n_dway;
    logic [AGE_W-1:0] r_hit_way, n_hit_way;
    logic [AGE_W-1:0] r_ref_age, n_ref_age;
    logic [AGE_W-1:0] r_inv_way, n_inv_way;
    logic [AGE_W-1:0] r_best_age, n_best_age;
    logic [AGE_W-1:0] r_best_way, n_best_way;
    logic [AGE_W-1:0] r_sel, n_sel;
    t_resp            r_resp, n_resp;

    // Datapath signals.
    logic              accept;
    logic              issue;
    logic [3:0]        ib_eff;
    logic [2:0]        wl_eff;
    logic [15:0]       lfsr_nx;
    logic              ram_we;
    logic [RAM_AW-1:0] ram_raddr;
    logic [RAM_AW-1:0] ram_waddr;
    logic [ENT_W-1:0]  ram_q;
    logic [ENT_W-1:0]  rd_entry;
    logic [ENT_W-1:0]  upd_entry;
    logic              e_valid;
    logic [AGE_W-1:0]  e_age;
    logic              unit_match;
    logic              unit_vict_dirty;
    t_upd_ctl          upd_ctl;

    assign accept  = start && (r_state == S_IDLE);
    assign issue   = (r_rd_way < r_ways);
    assign ib_eff  = (r_idx > 4'(SET_LOG)) ? 4'(SET_LOG) : r_idx;
    assign wl_eff  = ({1'b0, r_wl} > 3'(WAY_LOG)) ? 3'(WAY_LOG) : {1'b0, r_wl};
    assign lfsr_nx = lfsr_step(r_lfsr);

    // RAM addresses: the set selects a row of ways, the way counter a line.
    assign ram_raddr = RAM_AW'((32'(r_set) << WAY_LOG) | 32'(r_rd_way[AGE_W-1:0]));
    assign ram_waddr = RAM_AW'((32'(r_set) << WAY_LOG) | 32'(r_dway));
    assign ram_we    = (r_state == S_UPD) && r_dv;

    // A set never written since reset reads as all zero.
    assign rd_entry = r_set_valid[r_set] ? ram_q : '0;
    assign e_valid  = rd_entry[AGE_W+1];
    assign e_age    = rd_entry[AGE_W-1:0];

    assign upd_ctl.lru      = (r_rp == RP_LRU);
    assign upd_ctl.hit      = r_hit;
    assign upd_ctl.alloc    = r_alloc;
    assign upd_ctl.is_write = (r_mode == MODE_WRITE);
    assign upd_ctl.wb_write = (r_mode == MODE_WRITE) && (r_wp == WP_WRITE_BACK);

    sactc_ram #(
        .WIDTH (ENT_W),
        .DEPTH (RAM_DEPTH)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (upd_entry),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    sactc_way_unit #(
        .AGE_W (AGE_W)
    ) u_way_unit (
        .i_entry        (rd_entry),
        .i_tag          (r_tag),
        .i_way          (r_dway),
        .i_sel          (r_sel),
        .i_ref_age      (r_ref_age),
        .i_top          (r_top),
        .i_ctl          (upd_ctl),
        .o_match        (unit_match),
        .o_victim_dirty (unit_vict_dirty),
        .o_entry        (upd_entry)
    );

    // Sequencer and next-state logic.
    always_comb begin
        n_state     = r_state;
        n_wp        = r_wp;
        n_rp        = r_rp;
        n_off       = r_off;
        n_idx       = r_idx;
        n_wl        = r_wl;
        n_lfsr      = r_lfsr;
        n_set_valid = r_set_valid;
        n_rd_way    = r_rd_way;
        n_dv        = r_dv;
        n_hit       = r_hit;
        n_inv_found = r_inv_found;
        n_vict_wb   = r_vict_wb;
        n_alloc     = r_alloc;
        n_strobe    = 1'b0;
        n_mode      = r_mode;
        n_addr      = r_addr;
        n_set       = r_set;
        n_tag       = r_tag;
        n_ways      = r_ways;
        n_top       = r_top;
        n_dway      = r_dway;
        n_hit_way   = r_hit_way;
        n_ref_age   = r_ref_age;
        n_inv_way   = r_inv_way;
        n_best_age  = r_best_age;
        n_best_way  = r_best_way;
        n_sel       = r_sel;
        n_resp      = r_resp;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_mode  = i_req.mode;
                    n_addr  = i_req.address;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                // Split the address by the configured bit counts.
                n_set       = SET_W'((r_addr >> r_off) & ((32'd1 << ib_eff) - 32'd1));
                n_tag       = r_addr >> (5'(r_off) + 5'(ib_eff));
                n_ways      = CNT_W'(1) << wl_eff;
                n_top       = AGE_W'(n_ways - CNT_W'(1));
                n_rd_way    = '0;
                n_dv        = 1'b0;
                n_hit       = 1'b0;
                n_inv_found = 1'b0;
                n_state     = S_SCAN;
            end
            S_SCAN: begin
                // Issue one way read a cycle and examine the way read before.
                n_dv   = issue;
                n_dway = r_rd_way[AGE_W-1:0];
                if (issue) begin
                    n_rd_way = CNT_W'(r_rd_way + 1'b1);
                end else begin
                    n_state = S_VICT;
                end
                if (r_dv) begin
                    if (!r_hit && unit_match) begin
                        n_hit     = 1'b1;
                        n_hit_way = r_dway;
                        n_ref_age = e_age;
                    end
                    if (!r_inv_found && !e_valid) begin
                        n_inv_found = 1'b1;
                        n_inv_way   = r_dway;
                    end
                    if ((r_dway == '0) || (e_age > r_best_age)) begin
                        n_best_age = e_age;
                        n_best_way = r_dway;
                    end
                end
            end
            S_VICT: begin
                // Choose the way to update: hit, first free, oldest or random.
                n_alloc   = !r_hit && ((r_mode == MODE_READ) || (r_wp == WP_WRITE_BACK));
                n_vict_wb = 1'b0;
                n_rd_way  = '0;
                n_dv      = 1'b0;
                // A set touched for the first time has every way written, so
                // ways outside the current geometry hold zero as well.
                if (!r_set_valid[r_set]) begin
                    n_ways = CNT_W'(1) << WAY_LOG;
                end
                if (r_hit) begin
                    n_sel = r_hit_way;
                end else if (r_inv_found) begin
                    n_sel = r_inv_way;
                end else if (r_rp == RP_LRU) begin
                    n_sel = r_best_way;
                end else begin
                    n_sel = lfsr_nx[AGE_W-1:0] & r_top;
                    if (n_alloc) begin
                        n_lfsr = lfsr_nx;
                    end
                end
                n_state = S_UPD;
            end
            S_UPD: begin
                // Read each way again and write back its updated contents.
                n_dv   = issue;
                n_dway = r_rd_way[AGE_W-1:0];
                if (issue) begin
                    n_rd_way = CNT_W'(r_rd_way + 1'b1);
                end
                if (r_dv && unit_vict_dirty) begin
                    n_vict_wb = 1'b1;
                end
                if (!issue) begin
                    n_set_valid[r_set]  = 1'b1;
                    n_strobe            = 1'b1;
                    n_resp.hit          = r_hit;
                    n_resp.memory_fill  = r_alloc;
                    n_resp.memory_write = r_vict_wb || unit_vict_dirty ||
                                          ((r_mode == MODE_WRITE) &&
                                           (r_wp == WP_WRITE_THROUGH));
                    n_state             = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Configuration writes: user must write while idle; block does not check.
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_WRITE_POLICY:   n_wp  = i_cfg_data[0];
                CFG_REPLACE_POLICY: n_rp  = i_cfg_data[0];
                CFG_OFFSET_BITS:    n_off = i_cfg_data[3:0];
                CFG_INDEX_BITS:     n_idx = i_cfg_data[3:0];
                CFG_WAYS_LOG2:      n_wl  = i_cfg_data[1:0];
                CFG_RANDOM_SEED:    n_lfsr = (i_cfg_data == '0) ? 16'd1 : i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Control registers with synchronous reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wp        <= RST_WRITE_POLICY;
            r_rp        <= RST_REPLACE_POLICY;
            r_off       <= RST_OFFSET_BITS;
            r_idx       <= RST_INDEX_BITS;
            r_wl        <= RST_WAYS_LOG2;
            r_lfsr      <= RST_RANDOM_SEED;
            r_set_valid <= '0;
            r_rd_way    <= '0;
            r_dv        <= 1'b0;
            r_hit       <= 1'b0;
            r_inv_found <= 1'b0;
            r_vict_wb   <= 1'b0;
            r_alloc     <= 1'b0;
            r_strobe    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wp        <= n_wp;
            r_rp        <= n_rp;
            r_off       <= n_off;
            r_idx       <= n_idx;
            r_wl        <= n_wl;
            r_lfsr      <= n_lfsr;
            r_set_valid <= n_set_valid;
            r_rd_way    <= n_rd_way;
            r_dv        <= n_dv;
            r_hit       <= n_hit;
            r_inv_found <= n_inv_found;
            r_vict_wb   <= n_vict_wb;
            r_alloc     <= n_alloc;
            r_strobe    <= n_strobe;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_mode     <= n_mode;
        r_addr     <= n_addr;
        r_set      <= n_set;
        r_tag      <= n_tag;
        r_ways     <= n_ways;
        r_top      <= n_top;
        r_dway     <= n_dway;
        r_hit_way  <= n_hit_way;
        r_ref_age  <= n_ref_age;
        r_inv_way  <= n_inv_way;
        r_best_age <= n_best_age;
        r_best_way <= n_best_way;
        r_sel      <= n_sel;
        r_resp     <= n_resp;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_resp   = r_resp;

    // An accepted word keeps the block busy from the next cycle on.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("accepted word did not make the block busy");

    // A result is shown for one cycle only.
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe held for more than one cycle");

    // The tag RAM is written only during the update pass.
    a_write_in_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_UPD))
        else $error("tag RAM written outside the update pass");

    // A line fill never accompanies a hit.
    a_fill_not_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !(o_resp.hit && o_resp.memory_fill))
        else $error("result reports both a hit and a line fill");

    // The result follows the final update cycle.
    a_strobe_after_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ($past(r_state) == S_UPD) && !busy)
        else $error("result strobe outside its slot");

endmodule

### sv/sactc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module sactc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/sactc_way_unit.sv
// Shared per-way unit: tag compare during the scan and line update during the write pass.
`timescale 1ns / 1ps

module sactc_way_unit
    import sactc_pkg::*;
#(
    parameter int AGE_W = 3
) (
    input  logic [ADDR_W+AGE_W+1:0] i_entry,
    input  logic [ADDR_W-1:0]       i_tag,
    input  logic [AGE_W-1:0]        i_way,
    input  logic [AGE_W-1:0]        i_sel,
    input  logic [AGE_W-1:0]        i_ref_age,
    input  logic [AGE_W-1:0]        i_top,
    input  t_upd_ctl                i_ctl,
    output logic                    o_match,
    output logic                    o_victim_dirty,
    output logic [ADDR_W+AGE_W+1:0] o_entry
);

    logic [ADDR_W-1:0] e_tag;
    logic              e_valid;
    logic              e_dirty;
    logic [AGE_W-1:0]  e_age;
    logic              is_sel;
    logic [AGE_W-1:0]  age_inc;
    logic [ADDR_W-1:0] n_tag;
    logic              n_valid;
    logic              n_dirty;
    logic [AGE_W-1:0]  n_age;

    // Split the stored line into its fields.
    assign e_tag   = i_entry[ADDR_W+AGE_W+1 -: ADDR_W];
    assign e_valid = i_entry[AGE_W+1];
    assign e_dirty = i_entry[AGE_W];
    assign e_age   = i_entry[AGE_W-1:0];

    assign is_sel  = (i_way == i_sel);
    assign o_match = e_valid && (e_tag == i_tag);

    // Ageing saturates at the number of ways less one.
    assign age_inc = (e_age < i_top) ? AGE_W'(e_age + 1'b1) : i_top;

    // The chosen victim must be written back when it holds dirty data.
    assign o_victim_dirty = i_ctl.alloc && is_sel && e_valid && e_dirty;

    // New contents of the line after this access.
    always_comb begin
        n_tag   = e_tag;
        n_valid = e_valid;
        n_dirty = e_dirty;
        n_age   = e_age;
        if (i_ctl.hit) begin
            if (is_sel) begin
                n_dirty = e_dirty | i_ctl.wb_write;
                if (i_ctl.lru) begin
                    n_age = '0;
                end
            end else if (i_ctl.lru && (e_age < i_ref_age)) begin
                n_age = age_inc;
            end
        end else if (i_ctl.alloc) begin
            if (is_sel) begin
                n_tag   = i_tag;
                n_valid = 1'b1;
                n_dirty = i_ctl.is_write;
                n_age   = '0;
            end else if (i_ctl.lru && e_valid) begin
                n_age = age_inc;
            end
        end
    end

    assign o_entry = {n_tag, n_valid, n_dirty, n_age};

endmodule

### tb/tb_set_assoc_cache_tag_controller.sv
// Self-checking testbench for the set-associative cache tag controller.
`timescale 1ns / 1ps

module tb_set_assoc_cache_tag_controller;
    import sactc_pkg::*;

    localparam int NUM_SETS        = 256;
    localparam int NUM_WAYS        = 8;
    localparam int SET_BITS        = 8;
    localparam int WAY_BITS        = 3;
    localparam int CLK_HALF        = 6;
    localparam int SETTLE_CYCLES   = 2 * (2 * NUM_WAYS + 5);
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int RANDOM_ACCESSES = 1630;
    localparam int MAX_REPORTS     = 10;

    // Index with no register behind it; a write there must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

    typedef enum logic {ROW_ACCESS, ROW_REG} t_row_kind;

    // One row of the directed script: an access or a register write.
    typedef struct {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_data;
        t_req                  req;
        bit                    typed;
        t_resp                 resp;
    } t_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    t_req                  i_req;
    logic                  o_strobe;
    t_resp                 o_resp;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // Predicted copy of the tag store and the registers.
    logic [ADDR_W-1:0] tag_q [NUM_SETS][NUM_WAYS];
    bit                vld_q [NUM_SETS][NUM_WAYS];
    bit                dty_q [NUM_SETS][NUM_WAYS];
    logic [2:0]        age_q [NUM_SETS][NUM_WAYS];
    logic [15:0]       lfsr_q;
    logic              cfg_wp;
    logic              cfg_rp;
    logic [3:0]        cfg_off;
    logic [3:0]        cfg_ib;
    logic [1:0]        cfg_wl;

    t_resp             outstanding_resp[$];
    t_row              script[$];
    logic [ADDR_W-1:0] line_pool[48];

    int mismatches     = 0;
    int accesses       = 0;
    int results_seen   = 0;
    int hits           = 0;
    int fills          = 0;
    int mem_writes     = 0;
    int settings       = 1;
    int stalled_cycles = 0;

    set_assoc_cache_tag_controller #(
        .MAX_SETS(NUM_SETS),
        .MAX_WAYS(NUM_WAYS)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_req      (i_req),
        .o_strobe   (o_strobe),
        .o_resp     (o_resp),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    // Empty store and register values as after reset.
    function automatic void clear_cache_state();
        for (int s = 0; s < NUM_SETS; s++) begin
            for (int w = 0; w < NUM_WAYS; w++) begin
                tag_q[s][w] = '0;
                vld_q[s][w] = 1'b0;
                dty_q[s][w] = 1'b0;
                age_q[s][w] = '0;
            end
        end
        cfg_wp  = RST_WRITE_POLICY;
        cfg_rp  = RST_REPLACE_POLICY;
        cfg_off = RST_OFFSET_BITS;
        cfg_ib  = RST_INDEX_BITS;
        cfg_wl  = RST_WAYS_LOG2;
        lfsr_q  = RST_RANDOM_SEED;
    endfunction

    // Register write as the block sees it; a zero seed is loaded as one.
    function automatic void apply_reg_write(logic [CFG_IDX_W-1:0] idx,
                                            logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_WRITE_POLICY:   cfg_wp  = data[0];
            CFG_REPLACE_POLICY: cfg_rp  = data[0];
            CFG_OFFSET_BITS:    cfg_off = data[3:0];
            CFG_INDEX_BITS:     cfg_ib  = data[3:0];
            CFG_WAYS_LOG2:      cfg_wl  = data[1:0];
            CFG_RANDOM_SEED:    lfsr_q  = (data == '0) ? 16'd1 : data;
            default: ;
        endcase
    endfunction

    // Saturating age step; an age left above the top by a geometry change drops to it.
    function automatic logic [2:0] aged(logic [2:0] age, int top);
        return (int'(age) < top) ? age + 3'd1 : 3'(top);
    endfunction

    // Lookup, replacement and update of one access; returns the flags it raises.
    function automatic t_resp cache_access(t_req req);
        int          ib;
        int          wl;
        int          ways;
        int          top;
        int          set_i;
        int          sel;
        int          w;
        int          best;
        logic [31:0] tag;
        logic [2:0]  hit_age;
        bit          found;
        bit          have;
        bit          is_wr;
        bit          wb_wr;
        t_resp       r;

        r     = '0;
        is_wr = (req.mode == MODE_WRITE);
        wb_wr = is_wr && (cfg_wp == WP_WRITE_BACK);
        ib    = (cfg_ib > SET_BITS) ? SET_BITS : int'(cfg_ib);
        wl    = (cfg_wl > WAY_BITS) ? WAY_BITS : int'(cfg_wl);
        ways  = 1 << wl;
        top   = ways - 1;
        set_i = int'((req.address >> cfg_off) & ((32'h1 << ib) - 32'h1));
        tag   = req.address >> (int'(cfg_off) + ib);
        found = 1'b0;
        have  = 1'b0;
        sel   = 0;

        // Ways are searched in order; the first valid match wins.
        for (w = 0; w < ways; w++) begin
            if (!found && vld_q[set_i][w] && tag_q[set_i][w] == tag) begin
                found = 1'b1;
                sel   = w;
            end
        end

        if (found) begin
            r.hit = 1'b1;
            if (wb_wr) begin
                dty_q[set_i][sel] = 1'b1;
            end
            // Under LRU only the ways younger than the hit line get older.
            if (cfg_rp == RP_LRU) begin
                hit_age = age_q[set_i][sel];
                for (w = 0; w < ways; w++) begin
                    if (w != sel && age_q[set_i][w] < hit_age) begin
                        age_q[set_i][w] = aged(age_q[set_i][w], top);
                    end
                end
                age_q[set_i][sel] = '0;
            end
        end else if (!is_wr || wb_wr) begin
            r.memory_fill = 1'b1;
            for (w = 0; w < ways; w++) begin
                if (!have && !vld_q[set_i][w]) begin
                    sel  = w;
                    have = 1'b1;
                end
            end
            if (cfg_rp == RP_LRU) begin
                // Full set: the first of the oldest ways goes.
                if (!have) begin
                    best = -1;
                    for (w = 0; w < ways; w++) begin
                        if (int'(age_q[set_i][w]) > best) begin
                            best = int'(age_q[set_i][w]);
                            sel  = w;
                        end
                    end
                end
                for (w = 0; w < ways; w++) begin
                    if (w != sel && vld_q[set_i][w]) begin
                        age_q[set_i][w] = aged(age_q[set_i][w], top);
                    end
                end
            end else if (!have) begin
                // Galois LFSR step; the victim is taken from the new state.
                lfsr_q = (lfsr_q >> 1) ^ (lfsr_q[0] ? LFSR_TAPS : 16'h0000);
                sel    = int'(lfsr_q) & top;
            end
            if (vld_q[set_i][sel] && dty_q[set_i][sel]) begin
                r.memory_write = 1'b1;
            end
            tag_q[set_i][sel] = tag;
            vld_q[set_i][sel] = 1'b1;
            dty_q[set_i][sel] = is_wr;
            age_q[set_i][sel] = '0;
        end

        if (is_wr && cfg_wp == WP_WRITE_THROUGH) begin
            r.memory_write = 1'b1;
        end
        return r;
    endfunction

    function automatic t_row access_row(logic mode, logic [ADDR_W-1:0] addr);
        t_row r;
        r.kind        = ROW_ACCESS;
        r.reg_idx     = '0;
        r.reg_data    = '0;
        r.req.mode    = mode;
        r.req.address = addr;
        r.typed       = 1'b0;
        r.resp        = '0;
        return r;
    endfunction

    function automatic t_row checked_row(logic mode, logic [ADDR_W-1:0] addr,
                                         logic hit, logic fill, logic mwr);
        t_row r;
        r                   = access_row(mode, addr);
        r.typed             = 1'b1;
        r.resp.hit          = hit;
        r.resp.memory_fill  = fill;
        r.resp.memory_write = mwr;
        return r;
    endfunction

    function automatic t_row reg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        t_row r;
        r          = access_row(MODE_READ, '0);
        r.kind     = ROW_REG;
        r.reg_idx  = idx;
        r.reg_data = data;
        return r;
    endfunction

    // Random filler in the bits a register ignores.
    function automatic logic [CFG_DATA_W-1:0] pad_noise(logic [CFG_DATA_W-1:0] value,
                                                        logic [CFG_DATA_W-1:0] keep);
        return (CFG_DATA_W'($urandom) & ~keep) | (value & keep);
    endfunction

    function automatic void flag_error(string msg);
        if (mismatches < MAX_REPORTS) begin
            $display("%0t ns: %s", $time, msg);
        end
        mismatches++;
    endfunction

    // Offer one access word and hold it until the block takes it.
    task automatic send_access(t_req req, bit typed, t_resp want);
        t_resp predicted;
        @(negedge i_clk);
        start <= 1'b1;
        i_req <= req;
        do @(posedge i_clk); while (busy);
        predicted = cache_access(req);
        outstanding_resp.push_back(typed ? want : predicted);
        accesses++;
    endtask

    // Drop start for a number of cycles, with junk on the request bus.
    task automatic pause_sender(int cycles);
        t_req junk;
        junk.mode    = 1'($urandom_range(0, 1));
        junk.address = $urandom;
        @(negedge i_clk);
        start <= 1'b0;
        i_req <= junk;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    task automatic wait_all_results();
        while (outstanding_resp.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        apply_reg_write(idx, data);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Every result word is checked against the oldest outstanding prediction.
    always @(posedge i_clk) begin : resp_check
        t_resp want;
        if (i_rst_n === 1'b1 && o_strobe === 1'b1) begin
            results_seen++;
            if (o_resp.hit === 1'b1)          hits++;
            if (o_resp.memory_fill === 1'b1)  fills++;
            if (o_resp.memory_write === 1'b1) mem_writes++;
            if (outstanding_resp.size() == 0) begin
                flag_error($sformatf("result word %0d arrived with no access outstanding",
                                     results_seen));
            end else begin
                want = outstanding_resp.pop_front();
                if (o_resp !== want) begin
                    flag_error($sformatf(
                        "result word %0d: hit/fill/write expected %0b/%0b/%0b, got %0b/%0b/%0b",
                        results_seen, want.hit, want.memory_fill, want.memory_write,
                        o_resp.hit, o_resp.memory_fill, o_resp.memory_write));
                end
            end
        end
    end

    // Watchdog: too long without an accepted access, a result or a register write.
    always @(posedge i_clk) begin
        if (i_rst_n !== 1'b1 || (start && !busy) || o_strobe === 1'b1 || i_cfg_we) begin
            stalled_cycles <= 0;
        end else begin
            stalled_cycles <= stalled_cycles + 1;
        end
        if (stalled_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Reset, directed script, then random phases under changing settings.
    initial begin
        t_row              row;
        int                phase;
        int                phase_len;
        int                pool_size;
        int                hot_sets;
        int                ib_eff;
        int                burst_left;
        int                issued;
        bit                quiet;
        logic [ADDR_W-1:0] set_field;
        logic [ADDR_W-1:0] line_mask;
        logic [3:0]        off_v;
        logic [3:0]        ib_v;
        logic [1:0]        wl_v;
        logic              wp_v;
        logic              rp_v;
        t_req              req;

        i_rst_n    <= 1'b0;
        start      <= 1'b0;
        i_req      <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= '0;
        i_cfg_data <= '0;
        clear_cache_state();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Cold misses, a hit in the same line and a dirty victim under the reset setting.
        script.push_back(checked_row(MODE_WRITE, 32'h0000_0000, 1'b0, 1'b1, 1'b0));
        script.push_back(checked_row(MODE_READ,  32'h0000_000F, 1'b1, 1'b0, 1'b0));
        script.push_back(checked_row(MODE_READ,  32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0));
        script.push_back(access_row(MODE_READ,   32'h0000_0400));
        script.push_back(access_row(MODE_READ,   32'h0000_0800));
        script.push_back(access_row(MODE_READ,   32'h0000_0C00));
        script.push_back(checked_row(MODE_READ,  32'h0000_1000, 1'b0, 1'b1, 1'b1));
        script.push_back(access_row(MODE_WRITE,  32'h0000_0400));
        // Write-through: a write always goes to memory and never allocates.
        script.push_back(reg_row(CFG_WRITE_POLICY, CFG_DATA_W'(WP_WRITE_THROUGH)));
        script.push_back(checked_row(MODE_WRITE, 32'h0000_0400, 1'b1, 1'b0, 1'b1));
        script.push_back(checked_row(MODE_WRITE, 32'h7000_0000, 1'b0, 1'b0, 1'b1));
        script.push_back(access_row(MODE_READ,   32'h7000_0000));
        // Random victims from a zero seed, which must load as one.
        script.push_back(reg_row(CFG_REPLACE_POLICY, CFG_DATA_W'(RP_RANDOM)));
        script.push_back(reg_row(CFG_RANDOM_SEED, 16'h0000));
        script.push_back(access_row(MODE_READ,   32'h0001_0000));
        script.push_back(access_row(MODE_READ,   32'h0002_0000));
        script.push_back(access_row(MODE_READ,   32'h0003_0000));
        script.push_back(access_row(MODE_WRITE,  32'h0004_0000));
        // Oversized split: set count saturates and the tag keeps the extra bits.
        script.push_back(reg_row(CFG_WRITE_POLICY, CFG_DATA_W'(WP_WRITE_BACK)));
        script.push_back(reg_row(CFG_OFFSET_BITS, 16'd15));
        script.push_back(reg_row(CFG_INDEX_BITS, 16'd15));
        script.push_back(reg_row(CFG_WAYS_LOG2, 16'd3));
        script.push_back(access_row(MODE_WRITE,  32'hFFFF_FFFF));
        script.push_back(access_row(MODE_READ,   32'h0000_0000));
        script.push_back(access_row(MODE_READ,   32'h8000_7FFF));
        // One set of one way: every new tag evicts the last one.
        script.push_back(reg_row(CFG_OFFSET_BITS, 16'd0));
        script.push_back(reg_row(CFG_INDEX_BITS, 16'd0));
        script.push_back(reg_row(CFG_WAYS_LOG2, 16'd0));
        script.push_back(reg_row(CFG_REPLACE_POLICY, CFG_DATA_W'(RP_LRU)));
        script.push_back(access_row(MODE_READ,   32'h1234_5678));
        script.push_back(checked_row(MODE_READ,  32'h1234_5678, 1'b1, 1'b0, 1'b0));
        script.push_back(checked_row(MODE_WRITE, 32'hEDCB_A987, 1'b0, 1'b1, 1'b0));
        script.push_back(checked_row(MODE_READ,  32'h1234_5678, 1'b0, 1'b1, 1'b1));
        script.push_back(reg_row(CFG_SPARE, 16'hFFFF));
        script.push_back(checked_row(MODE_READ,  32'h1234_5678, 1'b1, 1'b0, 1'b0));
        script.push_back(reg_row(CFG_RANDOM_SEED, 16'hFFFF));

        foreach (script[i]) begin
            row = script[i];
            if (row.kind == ROW_REG) begin
                pause_sender(1);
                wait_all_results();
                write_reg(row.reg_idx, row.reg_data);
                settings++;
            end else begin
                send_access(row.req, row.typed, row.resp);
            end
        end

        // Random phases: each sets every geometry and policy register, then
        // hammers a pool of lines crowded into a few sets.
        issued = 0;
        phase  = 0;
        while (issued < RANDOM_ACCESSES) begin
            pause_sender(1);
            wait_all_results();
            case (phase)
                0: begin off_v = 4'd0;  ib_v = 4'd0;  wl_v = 2'd0; end
                1: begin off_v = 4'd15; ib_v = 4'd15; wl_v = 2'd3; end
                2: begin off_v = 4'd12; ib_v = 4'd8;  wl_v = 2'd3; end
                3: begin off_v = 4'd4;  ib_v = 4'd6;  wl_v = 2'd2; end
                default: begin
                    off_v = 4'($urandom_range(0, 15));
                    ib_v  = 4'($urandom_range(0, 15));
                    wl_v  = 2'($urandom_range(0, 3));
                end
            endcase
            wp_v = (phase < 4) ? phase[0] : 1'($urandom_range(0, 1));
            rp_v = (phase < 4) ? phase[1] : 1'($urandom_range(0, 1));
            write_reg(CFG_WRITE_POLICY,   pad_noise(CFG_DATA_W'(wp_v), 16'h0001));
            write_reg(CFG_REPLACE_POLICY, pad_noise(CFG_DATA_W'(rp_v), 16'h0001));
            write_reg(CFG_OFFSET_BITS,    pad_noise(CFG_DATA_W'(off_v), 16'h000F));
            write_reg(CFG_INDEX_BITS,     pad_noise(CFG_DATA_W'(ib_v), 16'h000F));
            write_reg(CFG_WAYS_LOG2,      pad_noise(CFG_DATA_W'(wl_v), 16'h0003));
            case (phase)
                0: write_reg(CFG_RANDOM_SEED, 16'h0000);
                1: write_reg(CFG_RANDOM_SEED, 16'hFFFF);
                2: write_reg(CFG_RANDOM_SEED, 16'h0001);
                default: begin
                    if ($urandom_range(0, 1) == 1) begin
                        write_reg(CFG_RANDOM_SEED, 16'($urandom_range(0, 65535)));
                    end
                end
            endcase
            settings++;

            // Pool of line addresses sharing a handful of sets.
            pool_size = $urandom_range(2, 48);
            hot_sets  = $urandom_range(1, 4);
            ib_eff    = (cfg_ib > SET_BITS) ? SET_BITS : int'(cfg_ib);
            set_field = ((32'h1 << ib_eff) - 32'h1) << cfg_off;
            line_mask = (32'h1 << cfg_off) - 32'h1;
            for (int i = 0; i < pool_size; i++) begin
                line_pool[i] = ($urandom & ~set_field)
                             | ((32'($urandom_range(0, hot_sets - 1)) << cfg_off) & set_field);
            end

            phase_len  = $urandom_range(80, 200);
            quiet      = ($urandom_range(0, 3) == 0);
            burst_left = $urandom_range(1, 30);
            for (int n = 0; n < phase_len && issued < RANDOM_ACCESSES; n++) begin
                req.mode = 1'($urandom_range(0, 1));
                if ($urandom_range(0, 99) < 80) begin
                    req.address = (line_pool[$urandom_range(0, pool_size - 1)] & ~line_mask)
                                | ($urandom & line_mask);
                end else begin
                    req.address = $urandom;
                end
                send_access(req, 1'b0, '0);
                issued++;
                if (!quiet) begin
                    burst_left--;
                    if (burst_left == 0) begin
                        pause_sender($urandom_range(1, 45));
                        burst_left = $urandom_range(1, 30);
                    end
                end
                // Now and then let the block run completely dry mid-phase.
                if ($urandom_range(0, 59) == 0) begin
                    pause_sender(1);
                    wait_all_results();
                end
            end
            phase++;
        end

        pause_sender(1);
        wait_all_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Sent %0d access words under %0d register settings, %0d result words back.",
                 accesses, settings, results_seen);
        $display("Results held %0d hits, %0d memory fills and %0d memory writes; %0d mismatches.",
                 hits, fills, mem_writes, mismatches);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
